// ===== sv/tdpt_pkg.sv =====
// tdpt_pkg: shared constants and controller/datapath command and status types
// for the trial division prime test block.
// No dependencies.
package tdpt_pkg;

   localparam int CANDIDATE_WIDTH     = 32;
   localparam int DEFAULT_VALUE_WIDTH = 32;

   // smallest prime, and the first odd trial divisor
   localparam int SMALLEST_PRIME = 2;
   localparam int FIRST_DIVISOR  = 3;

   typedef struct packed {
      logic load;       // capture a new candidate
      logic div_start;  // begin remainder of candidate by current divisor
      logic div_step;   // one restoring division step
      logic advance;    // move to the next odd divisor
   } cmd_type;

   typedef struct packed {
      logic lt_two;         // candidate below 2
      logic eq_two;         // candidate equals 2
      logic even;           // candidate is even
      logic bound_exceeded; // divisor squared above candidate
      logic div_last;       // this step is the final division step
      logic rem_zero;       // remainder is zero
   } status_type;

endpackage

// ===== sv/tdpt_channels.sv =====
// tdpt_channels: valid/ready channel interfaces for request and response.
// Depends on tdpt_pkg for the candidate width.
interface tdpt_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if;
   logic valid;
   logic ready;
   logic prime_flag;

   modport source (output valid, output prime_flag, input ready);
   modport sink   (input valid, input prime_flag, output ready);
endinterface

// ===== sv/tdpt_datapath.sv =====
// tdpt_datapath: candidate, odd divisor, running square and a bit-serial
// restoring remainder unit. Driven by tdpt_controller; depends on tdpt_pkg.
module tdpt_datapath #(
   parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic                                 clock,
   input  logic [tdpt_pkg::CANDIDATE_WIDTH-1:0] candidate,
   input  tdpt_pkg::cmd_type                    cmd,
   output tdpt_pkg::status_type                 status
);

   localparam int CntWidth = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
   localparam int SqWidth  = VALUE_WIDTH + 2;

   logic [VALUE_WIDTH-1:0] k_ff, k_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [SqWidth-1:0]     sq_ff, sq_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] sh_ff, sh_in;
   logic [CntWidth-1:0]    cnt_ff, cnt_in;

   logic [VALUE_WIDTH:0]   rem_shift;
   logic [VALUE_WIDTH:0]   rem_diff;
   logic                   rem_ge;

   // partial remainder shifted left with the next dividend bit
   assign rem_shift = {rem_ff, sh_ff[VALUE_WIDTH-1]};
   assign rem_diff  = rem_shift - {1'b0, d_ff};
   assign rem_ge    = rem_shift >= {1'b0, d_ff};

   always_comb begin
      k_in   = k_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      rem_in = rem_ff;
      sh_in  = sh_ff;
      cnt_in = cnt_ff;
      if (cmd.load) begin
         // bits above the datapath width are dropped
         k_in  = (VALUE_WIDTH)'(candidate);
         d_in  = (VALUE_WIDTH)'(tdpt_pkg::FIRST_DIVISOR);
         sq_in = (SqWidth)'(tdpt_pkg::FIRST_DIVISOR * tdpt_pkg::FIRST_DIVISOR);
      end
      if (cmd.div_start) begin
         rem_in = '0;
         sh_in  = k_ff;
         cnt_in = '0;
      end
      if (cmd.div_step) begin
         rem_in = rem_ge ? rem_diff[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
         sh_in  = {sh_ff[VALUE_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff + CntWidth'(1);
      end
      if (cmd.advance) begin
         // (d+2)^2 = d^2 + 4d + 4
         d_in  = d_ff + (VALUE_WIDTH)'(2);
         sq_in = sq_ff + {d_ff, 2'b00} + (SqWidth)'(4);
      end
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_in;
      d_ff   <= d_in;
      sq_ff  <= sq_in;
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
   end

   assign status.lt_two         = k_ff < (VALUE_WIDTH)'(tdpt_pkg::SMALLEST_PRIME);
   assign status.eq_two         = k_ff == (VALUE_WIDTH)'(tdpt_pkg::SMALLEST_PRIME);
   assign status.even           = ~k_ff[0];
   assign status.bound_exceeded = sq_ff > {2'b00, k_ff};
   assign status.div_last       = cnt_ff == CntWidth'(VALUE_WIDTH - 1);
   assign status.rem_zero       = rem_ff == '0;

endmodule

// ===== sv/tdpt_controller.sv =====
// tdpt_controller: sequencer for the prime test and the response register.
// Commands tdpt_datapath through tdpt_pkg::cmd_type; depends on tdpt_pkg.
module tdpt_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   output logic                 rsp_prime_flag,
   input  logic                 rsp_ready,
   input  tdpt_pkg::status_type status,
   output tdpt_pkg::cmd_type    cmd
);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StCheck  = 3'd1;
   localparam logic [2:0] StDiv    = 3'd2;
   localparam logic [2:0] StTest   = 3'd3;
   localparam logic [2:0] StFinish = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       result_ff, result_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_flag_ff, rsp_flag_in;

   assign req_ready      = state_ff == StIdle;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_prime_flag = rsp_flag_ff;

   always_comb begin
      state_in     = state_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_flag_in  = rsp_flag_ff;
      cmd          = '0;
      unique case (state_ff)
         StIdle: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (status.lt_two) begin
               result_in = 1'b0;
               state_in  = StFinish;
            end else if (status.eq_two) begin
               result_in = 1'b1;
               state_in  = StFinish;
            end else if (status.even) begin
               result_in = 1'b0;
               state_in  = StFinish;
            end else if (status.bound_exceeded) begin
               // no divisor up to the square root
               result_in = 1'b1;
               state_in  = StFinish;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = StDiv;
            end
         end
         StDiv: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = StTest;
            end
         end
         StTest: begin
            if (status.rem_zero) begin
               result_in = 1'b0;
               state_in  = StFinish;
            end else begin
               cmd.advance = 1'b1;
               state_in    = StCheck;
            end
         end
         StFinish: begin
            // wait for the response register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_flag_in  = result_ff;
               state_in     = StIdle;
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      result_ff   <= result_in;
      rsp_flag_ff <= rsp_flag_in;
   end

endmodule

// ===== sv/trial_division_prime_test.sv =====
// Trial division prime test, top level.
// Depends on tdpt_pkg, tdpt_channels, tdpt_controller and tdpt_datapath.
//
// req_if carries a 32-bit unsigned candidate; rsp_if returns prime_flag,
// 1 when the candidate is prime. Both are valid/ready channels; a transfer
// happens on a clock edge with valid and ready high. One response per request.
// Candidate bits at or above VALUE_WIDTH are ignored.
//
// One candidate is worked at a time; req_if.ready is high only while idle.
// Values below 2, 2 and even values are settled in the check state with no
// division. An odd candidate runs, per odd trial divisor, a bound check,
// one remainder bit per cycle and a zero test; the bit-serial remainder
// unit sets the run time of an odd candidate.
//
// The response sits in an output register; when rsp_if stalls, the block
// finishes the next candidate and holds it until the register frees up.
// Synchronous reset returns the sequencer to idle and drops rsp_if.valid.
module trial_division_prime_test #(
   parameter int VALUE_WIDTH = tdpt_pkg::DEFAULT_VALUE_WIDTH
) (
   input  logic     clock,
   input  logic     reset,
   tdpt_req_if.sink   req_if,
   tdpt_rsp_if.source rsp_if
);

   tdpt_pkg::cmd_type    cmd;
   tdpt_pkg::status_type status;

   tdpt_controller u_controller (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_if.valid),
      .req_ready      (req_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_prime_flag (rsp_if.prime_flag),
      .rsp_ready      (rsp_if.ready),
      .status         (status),
      .cmd            (cmd)
   );

   tdpt_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .candidate (req_if.candidate),
      .cmd       (cmd),
      .status    (status)
   );

endmodule
